@@ rtl/dbpt_pkg.sv @@
package dbpt_pkg;

    localparam int DESCRIPTOR_BITS = 256;
    localparam int WORD_BITS       = 64;
    localparam int COUNT_BITS      = 16;
    localparam int NUM_WORDS       = DESCRIPTOR_BITS / WORD_BITS;
    localparam int ROW_BITS        = $clog2(NUM_WORDS);
    localparam int LANE_BITS       = $clog2(WORD_BITS);
    localparam int INDEX_BITS      = ROW_BITS + LANE_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ROW_BITS-1:0]   LAST_ROW  = ROW_BITS'(NUM_WORDS - 1);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int IN_DATA_BITS  = 80;
    localparam int RESULT_BITS   = 4 * COUNT_BITS;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    typedef struct packed {
        logic                  prev_bit;
        logic [COUNT_BITS-1:0] run;
        logic [COUNT_BITS-1:0] longest;
        logic [COUNT_BITS-1:0] ones;
    } entry_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] upd_row;
        logic [ROW_BITS-1:0] rd_row;
    } rd_req_t;

    typedef struct packed {
        logic                add;
        logic                have_prev;
        logic [ROW_BITS-1:0] row;
        logic                upd_valid;
        logic                upd_fwd;
        logic                rd_valid;
        logic                rd_fwd;
        logic                same_row;
    } lane_ctrl_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

@@ rtl/dbpt_lane.sv @@
module dbpt_lane (
    input  logic                clk,
    input  dbpt_pkg::rd_req_t    rd_req,
    input  dbpt_pkg::lane_ctrl_t ctrl,
    input  logic                word_bit,
    output dbpt_pkg::entry_t     result
);
    import dbpt_pkg::*;

    entry_t mem [NUM_WORDS];
    entry_t upd_q_reg;
    entry_t rd_q_reg;
    entry_t wr_data_reg;
    entry_t upd_base;
    entry_t rd_base;
    entry_t upd;
    logic [COUNT_BITS-1:0] run_new;

    always_ff @(posedge clk)
    begin
        if (ctrl.add)
        begin
            mem[ctrl.row] <= upd;
            wr_data_reg   <= upd;
        end
        upd_q_reg <= mem[rd_req.upd_row];
        rd_q_reg  <= mem[rd_req.rd_row];
    end

    always_comb
    begin
        if (ctrl.upd_fwd)
        begin
            upd_base = wr_data_reg;
        end
        else if (ctrl.upd_valid)
        begin
            upd_base = upd_q_reg;
        end
        else
        begin
            upd_base = '0;
        end

        if (ctrl.rd_fwd)
        begin
            rd_base = wr_data_reg;
        end
        else if (ctrl.rd_valid)
        begin
            rd_base = rd_q_reg;
        end
        else
        begin
            rd_base = '0;
        end
    end

    always_comb
    begin
        run_new = (upd_base.prev_bit == word_bit) ? sat_inc(upd_base.run) : '0;
        upd = upd_base;
        upd.prev_bit = word_bit;
        if (ctrl.have_prev)
        begin
            upd.run = run_new;
            if (upd_base.longest < run_new)
            begin
                upd.longest = run_new;
            end
        end
        if (word_bit)
        begin
            upd.ones = sat_inc(upd_base.ones);
        end
    end

    assign result = (ctrl.add && ctrl.same_row) ? upd : rd_base;

endmodule

@@ rtl/dbpt_fifo.sv @@
module dbpt_fifo (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic [dbpt_pkg::RESULT_BITS-1:0]      push_data,
    input  logic                                  pop,
    output logic                                  out_valid,
    output logic [dbpt_pkg::RESULT_BITS-1:0]      out_data,
    output logic [dbpt_pkg::FIFO_CNT_BITS-1:0]    count
);
    import dbpt_pkg::*;

    logic [RESULT_BITS-1:0]   slot [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic [FIFO_CNT_BITS-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = slot[rd_ptr_reg];
    assign count     = count_reg;

endmodule

@@ rtl/descriptor_bit_permanence_tracker_top.sv @@
// An accepted transaction is registered in the b_* stage and its result is then queued for
// the master side. Throughput: one transaction per cycle; each of the 64 bit lanes reads two
// rows of its four-row statistics memory per transaction, writes one on an add and forwards
// the previous write. Input stalls only when the four-entry result queue would overflow.
// Reset (rst_n low, asynchronous) clears the descriptor count, row valid bits and the queue.
module descriptor_bit_permanence_tracker_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // descriptor_word [63:0], word_index [65:64], bit_index [73:66], zero [79:74]
    input  logic [dbpt_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // command [0]
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // current_run [15:0], longest_run [31:16], ones_count [47:32], descriptors_seen [63:48]
    output logic [dbpt_pkg::RESULT_BITS-1:0]      m_axis_tdata
);
    import dbpt_pkg::*;

    logic [WORD_BITS-1:0]  in_word;
    logic [ROW_BITS-1:0]   in_widx;
    logic [INDEX_BITS-1:0] in_bidx;
    logic                  accept;

    logic                  b_valid_reg;
    logic                  b_add_reg;
    logic [WORD_BITS-1:0]  b_word_reg;
    logic [ROW_BITS-1:0]   b_widx_reg;
    logic [INDEX_BITS-1:0] b_bidx_reg;
    logic                  upd_valid_reg;
    logic                  rd_valid_reg;

    logic                  wr_valid_reg;
    logic [ROW_BITS-1:0]   wr_row_reg;
    logic [NUM_WORDS-1:0]  rows_valid_reg;
    logic [NUM_WORDS-1:0]  rows_valid_next;
    logic                  have_prev_reg;
    logic                  have_prev_next;
    logic [COUNT_BITS-1:0] desc_reg;
    logic [COUNT_BITS-1:0] desc_next;

    logic                  write_en;
    rd_req_t               rd_req;
    lane_ctrl_t            ctrl;
    entry_t                lane_result [WORD_BITS];
    entry_t                picked;
    logic [RESULT_BITS-1:0] result;
    logic [FIFO_CNT_BITS-1:0] fifo_count;

    assign in_word = s_axis_tdata[WORD_BITS-1:0];
    assign in_widx = s_axis_tdata[WORD_BITS +: ROW_BITS];
    assign in_bidx = s_axis_tdata[WORD_BITS + ROW_BITS +: INDEX_BITS];

    assign s_axis_tready = ((fifo_count + FIFO_CNT_BITS'(b_valid_reg)) < FIFO_CNT_BITS'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign write_en      = b_valid_reg && b_add_reg;

    assign rd_req.upd_row = in_widx;
    assign rd_req.rd_row  = in_bidx[INDEX_BITS-1 -: ROW_BITS];

    always_comb
    begin
        ctrl.add       = write_en;
        ctrl.have_prev = have_prev_reg;
        ctrl.row       = b_widx_reg;
        ctrl.upd_valid = upd_valid_reg;
        ctrl.upd_fwd   = wr_valid_reg && (wr_row_reg == b_widx_reg);
        ctrl.rd_valid  = rd_valid_reg;
        ctrl.rd_fwd    = wr_valid_reg && (wr_row_reg == b_bidx_reg[INDEX_BITS-1 -: ROW_BITS]);
        ctrl.same_row  = (b_widx_reg == b_bidx_reg[INDEX_BITS-1 -: ROW_BITS]);
    end

    always_comb
    begin
        rows_valid_next = rows_valid_reg;
        have_prev_next  = have_prev_reg;
        desc_next       = desc_reg;
        if (write_en)
        begin
            rows_valid_next[b_widx_reg] = 1'b1;
            if (b_widx_reg == LAST_ROW)
            begin
                have_prev_next = 1'b1;
                desc_next      = sat_inc(desc_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg    <= 1'b0;
            wr_valid_reg   <= 1'b0;
            rows_valid_reg <= '0;
            have_prev_reg  <= 1'b0;
            desc_reg       <= '0;
        end
        else
        begin
            b_valid_reg    <= accept;
            wr_valid_reg   <= write_en;
            rows_valid_reg <= rows_valid_next;
            have_prev_reg  <= have_prev_next;
            desc_reg       <= desc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_add_reg     <= (s_axis_tuser == CMD_ADD);
        b_word_reg    <= in_word;
        b_widx_reg    <= in_widx;
        b_bidx_reg    <= in_bidx;
        upd_valid_reg <= rows_valid_reg[in_widx];
        rd_valid_reg  <= rows_valid_reg[in_bidx[INDEX_BITS-1 -: ROW_BITS]];
        wr_row_reg    <= b_widx_reg;
    end

    for (genvar g = 0; g < WORD_BITS; g++)
    begin : g_lane
        dbpt_lane u_lane (
            .clk      (clk),
            .rd_req   (rd_req),
            .ctrl     (ctrl),
            .word_bit (b_word_reg[g]),
            .result   (lane_result[g])
        );
    end

    assign picked = lane_result[b_bidx_reg[LANE_BITS-1:0]];
    assign result = {desc_next, picked.ones, picked.longest, picked.run};

    dbpt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (b_valid_reg),
        .push_data (result),
        .pop       (m_axis_tvalid && m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .count     (fifo_count)
    );

endmodule
